// ===== rtl/core/assert_macros.svh =====
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("delayed implication failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`else
`define ASSERT_DELAY(lbl, clk, rst_n, ante, n, cons)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ovl_pkg.sv =====
package ovl_pkg;

  localparam int COORD_W     = 16;
  localparam int FRAC_BITS   = 16;
  localparam int INV_W       = 24;
  localparam int D_W         = COORD_W + 1;
  localparam int MAG_W       = COORD_W;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int PROD_W      = SQ_W + INV_W;
  localparam int S_W         = PROD_W + 2;
  localparam int SAT_SHIFT   = 28;
  localparam int Q_W         = 2 * FRAC_BITS + 32 - SAT_SHIFT;
  localparam int R_W         = FRAC_BITS + 2;
  localparam int DIV_STAGES  = Q_W;
  localparam int SQRT_STAGES = R_W;
  localparam int FRAC_LAT    = DIV_STAGES + SQRT_STAGES;
  localparam int FRONT_LAT   = 4;
  localparam int BACK_LAT    = 2;
  localparam int LATENCY     = FRONT_LAT + FRAC_LAT + BACK_LAT;
  localparam int PM_W        = R_W + 1 + D_W;
  localparam int T_W         = PM_W + 1;

  localparam logic [S_W-1:0] SAT_LIMIT = S_W'(1) << SAT_SHIFT;
  localparam logic [R_W-1:0] R_MAX     = '1;
  localparam logic [R_W:0]   ONE_Q     = (R_W + 1)'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic        [INV_W-1:0]   inv_rad_sq_a_x;
    logic        [INV_W-1:0]   inv_rad_sq_a_y;
    logic        [INV_W-1:0]   inv_rad_sq_a_z;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic        [INV_W-1:0]   inv_rad_sq_b_x;
    logic        [INV_W-1:0]   inv_rad_sq_b_y;
    logic        [INV_W-1:0]   inv_rad_sq_b_z;
  } ovl_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] contact_x;
    logic signed [COORD_W-1:0] contact_y;
    logic signed [COORD_W-1:0] contact_z;
  } ovl_out_t;

  // Center difference and center sum per axis, carried beside the fraction units.
  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    logic [2:0][D_W-1:0] ab;
  } ovl_side_t;

endpackage

// ===== rtl/core/ovl_front.sv =====
module ovl_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  ovl_pkg::ovl_in_t          in_i,
  output logic                      valid_o,
  output logic [ovl_pkg::S_W-1:0]   s_a_o,
  output logic [ovl_pkg::S_W-1:0]   s_b_o,
  output ovl_pkg::ovl_side_t        side_o
);
  import ovl_pkg::*;

  logic [FRONT_LAT-1:0] v_q, v_d;
  ovl_side_t side_q [FRONT_LAT];
  ovl_side_t side_d;
  logic [2:0][INV_W-1:0] ia1_q, ib1_q, ia2_q, ib2_q;
  logic [2:0][SQ_W-1:0] sq_q, sq_d;
  logic [2:0][PROD_W-1:0] pa_q, pb_q, pa_d, pb_d;
  logic [S_W-1:0] sa_q, sb_q, sa_d, sb_d;
  logic [2:0][COORD_W-1:0] ca, cb;

  assign ca = {in_i.center_a_z, in_i.center_a_y, in_i.center_a_x};
  assign cb = {in_i.center_b_z, in_i.center_b_y, in_i.center_b_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_d.d[k]  = {ca[k][COORD_W-1], ca[k]} - {cb[k][COORD_W-1], cb[k]};
      side_d.ab[k] = {ca[k][COORD_W-1], ca[k]} + {cb[k][COORD_W-1], cb[k]};
    end
  end

  always_comb begin
    logic [D_W-1:0] dv, neg;
    logic [MAG_W-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      dv  = side_q[0].d[k];
      neg = -dv;
      mag = dv[D_W-1] ? neg[MAG_W-1:0] : dv[MAG_W-1:0];
      sq_d[k] = mag * mag;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = PROD_W'(sq_q[k]) * PROD_W'(ia2_q[k]);
      pb_d[k] = PROD_W'(sq_q[k]) * PROD_W'(ib2_q[k]);
    end
  end

  always_comb begin
    sa_d = S_W'(pa_q[0]) + S_W'(pa_q[1]) + S_W'(pa_q[2]);
    sb_d = S_W'(pb_q[0]) + S_W'(pb_q[1]) + S_W'(pb_q[2]);
  end

  assign v_d = {v_q[FRONT_LAT-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s < FRONT_LAT; s++) begin
      side_q[s] <= side_q[s-1];
    end
    ia1_q <= {in_i.inv_rad_sq_a_z, in_i.inv_rad_sq_a_y, in_i.inv_rad_sq_a_x};
    ib1_q <= {in_i.inv_rad_sq_b_z, in_i.inv_rad_sq_b_y, in_i.inv_rad_sq_b_x};
    ia2_q <= ia1_q;
    ib2_q <= ib1_q;
    sq_q  <= sq_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
  end

  assign valid_o = v_q[FRONT_LAT-1];
  assign s_a_o   = sa_q;
  assign s_b_o   = sb_q;
  assign side_o  = side_q[FRONT_LAT-1];

endmodule

// ===== rtl/core/ovl_frac.sv =====
module ovl_frac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [ovl_pkg::S_W-1:0] s_i,
  output logic                    valid_o,
  output logic [ovl_pkg::R_W-1:0] r_o
);
  import ovl_pkg::*;

  // Restoring division of 2^(2F+32) by s, one quotient bit per stage. The upper
  // quotient bits are known zero for any unsaturated s, so the remainder starts there.
  localparam logic [S_W-1:0] REM_INIT = S_W'(1) << SAT_SHIFT;

  logic             dv_q   [DIV_STAGES];
  logic [S_W-1:0]   rem_q  [DIV_STAGES];
  logic [S_W-1:0]   ds_q   [DIV_STAGES];
  logic [Q_W-1:0]   quo_q  [DIV_STAGES];
  logic             dsat_q [DIV_STAGES];

  logic             sv_q   [SQRT_STAGES];
  logic [Q_W-1:0]   q_q    [SQRT_STAGES];
  logic [R_W-1:0]   root_q [SQRT_STAGES];
  logic             ssat_q [SQRT_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic           v_p, sat_p;
    logic [S_W-1:0] rem_p, s_p;
    logic [Q_W-1:0] quo_p;
    logic [S_W:0]   sh, diff;
    logic           ge;

    if (g == 0) begin : g_head
      assign v_p   = valid_i;
      assign rem_p = REM_INIT;
      assign s_p   = s_i;
      assign quo_p = '0;
      assign sat_p = (s_i <= SAT_LIMIT);
    end else begin : g_body
      assign v_p   = dv_q[g-1];
      assign rem_p = rem_q[g-1];
      assign s_p   = ds_q[g-1];
      assign quo_p = quo_q[g-1];
      assign sat_p = dsat_q[g-1];
    end

    assign sh   = {rem_p, 1'b0};
    assign diff = sh - {1'b0, s_p};
    assign ge   = (sh >= {1'b0, s_p});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[g] <= 1'b0;
      end else begin
        dv_q[g] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? diff[S_W-1:0] : sh[S_W-1:0];
      ds_q[g]   <= s_p;
      quo_q[g]  <= {quo_p[Q_W-2:0], ge};
      dsat_q[g] <= sat_p;
    end
  end

  // Square root one result bit per stage, most significant first.
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    localparam logic [R_W-1:0] BIT = R_W'(1) << (R_W - 1 - g);
    logic           v_p, sat_p;
    logic [Q_W-1:0] q_p, sq;
    logic [R_W-1:0] root_p, cand;

    if (g == 0) begin : g_head
      assign v_p    = dv_q[DIV_STAGES-1];
      assign q_p    = quo_q[DIV_STAGES-1];
      assign root_p = '0;
      assign sat_p  = dsat_q[DIV_STAGES-1];
    end else begin : g_body
      assign v_p    = sv_q[g-1];
      assign q_p    = q_q[g-1];
      assign root_p = root_q[g-1];
      assign sat_p  = ssat_q[g-1];
    end

    assign cand = root_p | BIT;
    assign sq   = Q_W'(cand) * Q_W'(cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[g] <= 1'b0;
      end else begin
        sv_q[g] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      q_q[g]    <= q_p;
      root_q[g] <= (sq <= q_p) ? cand : root_p;
      ssat_q[g] <= sat_p;
    end
  end

  assign valid_o = sv_q[SQRT_STAGES-1];
  assign r_o     = ssat_q[SQRT_STAGES-1] ? R_MAX : root_q[SQRT_STAGES-1];

endmodule

// ===== rtl/core/ovl_back.sv =====
module ovl_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [ovl_pkg::R_W-1:0] r_a_i,
  input  logic [ovl_pkg::R_W-1:0] r_b_i,
  input  ovl_pkg::ovl_side_t      side_i,
  output logic                    valid_o,
  output ovl_pkg::ovl_out_t       out_o
);
  import ovl_pkg::*;

  logic                   va_q, vb_q;
  logic                   hit_q, hit_d;
  logic [2:0][PM_W-1:0]   prod_q, prod_d;
  logic [2:0][D_W-1:0]    ab_q;
  ovl_out_t               out_q, out_d;
  logic [2:0][COORD_W-1:0] cont;

  always_comb begin
    logic [R_W:0] rsum;
    logic signed [R_W:0] dr;
    logic signed [PM_W-1:0] p;
    rsum  = {1'b0, r_a_i} + {1'b0, r_b_i};
    hit_d = (rsum >= ONE_Q);
    dr    = $signed({1'b0, r_b_i}) - $signed({1'b0, r_a_i});
    for (int k = 0; k < 3; k++) begin
      p = dr * $signed(side_i.d[k]);
      prod_d[k] = p;
    end
  end

  // Floor by arithmetic shift, then clamp when the bits above the sign disagree.
  always_comb begin
    logic signed [T_W-1:0] tot, c;
    logic [T_W-COORD_W:0] upper;
    for (int k = 0; k < 3; k++) begin
      tot   = $signed(prod_q[k]) + ($signed(ab_q[k]) <<< FRAC_BITS);
      c     = tot >>> (FRAC_BITS + 1);
      upper = c[T_W-1:COORD_W-1];
      if ((&upper) || !(|upper)) begin
        cont[k] = c[COORD_W-1:0];
      end else if (c[T_W-1]) begin
        cont[k] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        cont[k] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
    out_d.hit       = hit_q;
    out_d.contact_x = cont[0];
    out_d.contact_y = cont[1];
    out_d.contact_z = cont[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    prod_q <= prod_d;
    ab_q   <= side_i.ab;
    out_q  <= out_d;
  end

  assign valid_o = vb_q;
  assign out_o   = out_q;

endmodule

// ===== rtl/core/ellipsoid_overlap_contact.sv =====
// Ellipsoid overlap test and contact point for two axis-aligned ellipsoids.
// Input channel: an item (both centers and per-axis inverse squared radii) is
// transferred on a rising edge with start high and busy low. busy stays
// low: the block is a pipeline that takes one item in every cycle.
// Result channel: strobe_o is high for one cycle with out_o holding hit and
// the contact point; the transfer completes at the end of that cycle.
// An accepted item runs through the front stages that form the weighted
// squared distances, the bit-per-stage division, the bit-per-stage square
// root, and the back stages that form the hit flag and the saturated contact
// point. Throughput is one item per cycle; results leave in the order the
// items came in.
// Reset clears only the valid bits of the pipeline, so no strobe appears until
// an item has travelled the full length. The receiver cannot stall; results
// leave whenever they are done.
`include "assert_macros.svh"
module ellipsoid_overlap_contact (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ovl_pkg::ovl_in_t  in_i,
  output logic              strobe_o,
  output ovl_pkg::ovl_out_t out_o
);
  import ovl_pkg::*;

  logic               acc;
  logic               fv, rva, rvb;
  logic [S_W-1:0]     s_a, s_b;
  logic [R_W-1:0]     r_a, r_b;
  ovl_side_t          side;
  ovl_side_t          side_dly_q [FRAC_LAT];
  logic               same_ctr;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  ovl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .in_i    (in_i),
    .valid_o (fv),
    .s_a_o   (s_a),
    .s_b_o   (s_b),
    .side_o  (side)
  );

  ovl_frac u_frac_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .s_i     (s_a),
    .valid_o (rva),
    .r_o     (r_a)
  );

  ovl_frac u_frac_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv),
    .s_i     (s_b),
    .valid_o (rvb),
    .r_o     (r_b)
  );

  // Center difference and sum wait beside the fraction units.
  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= side;
    for (int s = 1; s < FRAC_LAT; s++) begin
      side_dly_q[s] <= side_dly_q[s-1];
    end
  end

  ovl_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rva && rvb),
    .r_a_i   (r_a),
    .r_b_i   (r_b),
    .side_i  (side_dly_q[FRAC_LAT-1]),
    .valid_o (strobe_o),
    .out_o   (out_o)
  );

  assign same_ctr = (in_i.center_a_x == in_i.center_b_x) &&
                    (in_i.center_a_y == in_i.center_b_y) &&
                    (in_i.center_a_z == in_i.center_b_z);

  `ASSERT_DELAY(a_accept_gives_result, clk_i, rst_ni, acc, LATENCY, strobe_o)
  `ASSERT_IMPLY(a_result_had_item, clk_i, rst_ni, strobe_o, $past(acc, LATENCY))
  `ASSERT_DELAY(a_same_center_hits, clk_i, rst_ni, acc && same_ctr, LATENCY, out_o.hit)

endmodule
